// File: rtl/bclc_pkg.sv
// Package for the bounded list block: sizes, opcode and status codes,
// controller states and the command that is broadcast to the storage cells.
// No dependencies.
package bclc_pkg;

  localparam int unsigned CAPACITY  = 64;
  localparam int unsigned IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned ECNT_W    = 9;
  localparam int unsigned GRP_SIZE  = 8;
  localparam int unsigned NUM_GRP   = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_SET    = 2'd1,
    OP_GET    = 2'd2,
    OP_REMOVE = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_e;

  // Broadcast to every cell during the execute cycle
  typedef struct packed {
    logic                     en;
    opcode_e                  op;
    logic [IDX_W-1:0]         pos;
    logic [IDX_W-1:0]         fill;
    logic signed [WORD_W-1:0] value;
  } cell_cmd_t;

endpackage

// File: rtl/bclc_if.sv
// Handshake channels of the bounded list block: request and result.
// Depends on bclc_pkg.
interface bclc_in_if import bclc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               opcode;
  logic [POS_W-1:0]         position;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output opcode, output position, output value, input ready);
  modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

interface bclc_out_if import bclc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] read_value;
  logic [1:0]               status;
  logic [ECNT_W-1:0]        entry_count;

  modport source (output valid, output read_value, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input read_value, input status, input entry_count,
                  output ready);
endinterface

// File: rtl/bclc_cell.sv
// One storage cell of the list: holds one word, takes a write, shifts in
// its upper neighbor on a remove, and drives its word onto the read gather.
// Depends on bclc_pkg.
module bclc_cell import bclc_pkg::*; (
  input  logic                     clk_i,
  input  cell_cmd_t                cmd_i,
  input  logic [IDX_W-1:0]         idx_i,
  input  logic signed [WORD_W-1:0] next_i,
  output logic signed [WORD_W-1:0] data_o,
  output logic signed [WORD_W-1:0] rd_o
);

  logic signed [WORD_W-1:0] data_q;
  logic signed [WORD_W-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (cmd_i.en) begin
      unique case (cmd_i.op)
        OP_PUSH:   if (idx_i == cmd_i.fill) data_d = cmd_i.value;
        OP_SET:    if (idx_i == cmd_i.pos)  data_d = cmd_i.value;
        OP_REMOVE: if (idx_i >= cmd_i.pos)  data_d = next_i;
        default:   data_d = data_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = (idx_i == cmd_i.pos) ? data_q : '0;

endmodule

// File: rtl/bounds_checked_list_with_compaction.sv
// Top level of the bounded list: controller, row of storage cells and the
// registered read gather. Depends on bclc_pkg, bclc_if and bclc_cell.
//
// Usage:
//   in_i  carries one operation per item: opcode (push, set, get, remove),
//         position and value. It is taken when valid and ready are high.
//   out_o returns exactly one result per item: read_value, status and the
//         entry count after the operation.
//   Each item passes three steps: capture and bounds check, execute in the
//   cell row (cells from the position up shift in parallel on a remove),
//   then gather of the read word into the output register. A new item is
//   taken only once the last one has left its gather step; the gather over
//   the cells sets the extra step.
//   When the receiver stalls, the result waits in the output register; one
//   further item may be taken and executed, and it then holds in its last
//   step until the output register frees up.
//   Reset empties the list, clears the output valid and returns to idle; no
//   clearing pass is needed, since entries above the count are never read.
module bounds_checked_list_with_compaction import bclc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  bclc_in_if.sink    in_i,
  bclc_out_if.source out_o
);

  state_e state_q, state_d;

  opcode_e                  op_q;
  logic [POS_W-1:0]         pos_q;
  logic signed [WORD_W-1:0] val_q;
  status_e                  st_q;
  status_e                  st_d;
  logic [CNT_W-1:0]         fill_q, fill_d;

  logic accept;
  logic cell_en;
  logic load_out;

  cell_cmd_t cmd;

  logic signed [WORD_W-1:0] data  [CAPACITY];
  logic signed [WORD_W-1:0] rd    [CAPACITY];
  logic signed [WORD_W-1:0] grp_d [NUM_GRP];
  logic signed [WORD_W-1:0] grp_q [NUM_GRP];
  logic signed [WORD_W-1:0] gathered;
  logic signed [WORD_W-1:0] rdval;

  logic                     out_valid_q;
  logic signed [WORD_W-1:0] out_rd_q;
  status_e                  out_st_q;
  logic [CNT_W-1:0]         out_cnt_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_i.valid) state_d = S_EXEC;
      S_EXEC:  state_d = S_READ;
      S_READ:  if (!out_valid_q || out_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    in_i.ready = 1'b0;
    cell_en    = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      S_IDLE:  in_i.ready = 1'b1;
      S_EXEC:  cell_en    = 1'b1;
      S_READ:  load_out   = !out_valid_q || out_o.ready;
      default: in_i.ready = 1'b0;
    endcase
  end

  assign accept = in_i.valid && in_i.ready;

  // bounds check at capture; fill changes only in the execute step of the item in flight
  always_comb begin
    st_d = ST_OK;
    if (opcode_e'(in_i.opcode) == OP_PUSH) begin
      if (fill_q == CNT_W'(CAPACITY)) st_d = ST_FULL;
    end else if ({1'b0, in_i.position} >= (POS_W + 1)'(fill_q)) begin
      st_d = ST_BOUNDS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= opcode_e'(in_i.opcode);
      pos_q <= in_i.position;
      val_q <= in_i.value;
      st_q  <= st_d;
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (cell_en && st_q == ST_OK) begin
      if (op_q == OP_PUSH)   fill_d = fill_q + CNT_W'(1);
      if (op_q == OP_REMOVE) fill_d = fill_q - CNT_W'(1);
    end
  end

  // position is below the count whenever the command is enabled, except on a push
  always_comb begin
    cmd.en    = cell_en && (st_q == ST_OK);
    cmd.op    = op_q;
    cmd.pos   = pos_q[IDX_W-1:0];
    cmd.fill  = fill_q[IDX_W-1:0];
    cmd.value = val_q;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [WORD_W-1:0] next;
    if (i == CAPACITY - 1) begin : g_last
      assign next = data[i];
    end else begin : g_mid
      assign next = data[i+1];
    end
    bclc_cell u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .idx_i  (IDX_W'(i)),
      .next_i (next),
      .data_o (data[i]),
      .rd_o   (rd[i])
    );
  end

  // first gather level: one OR per group of cells, registered
  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GRP_SIZE; k++) begin
        if (g * GRP_SIZE + k < CAPACITY) grp_d[g] = grp_d[g] | rd[g * GRP_SIZE + k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cell_en) grp_q <= grp_d;
  end

  always_comb begin
    gathered = '0;
    for (int g = 0; g < NUM_GRP; g++) gathered = gathered | grp_q[g];
  end

  always_comb begin
    rdval = '0;
    if (op_q == OP_GET) begin
      if (st_q == ST_OK)          rdval = gathered;
      else if (st_q == ST_BOUNDS) rdval = '1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_rd_q  <= rdval;
      out_st_q  <= st_q;
      out_cnt_q <= fill_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.read_value  = out_rd_q;
  assign out_o.status      = out_st_q;
  assign out_o.entry_count = ECNT_W'(out_cnt_q);

endmodule
